/* src/csht_pkg.sv */
// csht_pkg: shared types and constants of the call-site hash counter table
// no dependencies; used by every module under src except csht_ram

package csht_pkg;

  localparam int unsigned Slots     = 8192;
  localparam int unsigned SlotAw    = $clog2(Slots);
  localparam int unsigned IdW       = 14;
  localparam int unsigned SizeW     = 48;
  localparam int unsigned HashW     = 32;
  localparam int unsigned FramesW   = 5;
  localparam int unsigned DigestW   = 64;
  localparam int unsigned BytesW    = 64;
  localparam int unsigned AllocsW   = 32;
  localparam int unsigned MaxFrames = 20;

  localparam logic [FramesW-1:0] FramesSat = FramesW'(MaxFrames);
  localparam logic [IdW-1:0]     OccLimit  = IdW'(Slots - 1);
  localparam logic [SizeW-1:0]   ThrReset  = SizeW'(16 * 1024);

  localparam logic [1:0] StatusDone      = 2'd0;
  localparam logic [1:0] StatusUntracked = 2'd1;
  localparam logic [1:0] StatusFull      = 2'd2;
  localparam logic [1:0] StatusBadId     = 2'd3;

  localparam logic KindRecord  = 1'b0;
  localparam logic KindRelease = 1'b1;

  localparam logic CfgEnable    = 1'b0;
  localparam logic CfgThreshold = 1'b1;

  typedef struct packed {
    logic                 live;
    logic [HashW-1:0]     hash;
    logic [FramesW-1:0]   frames;
    logic [DigestW-1:0]   digest;
    logic [BytesW-1:0]    bytes;
    logic [AllocsW-1:0]   allocs;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic read;
    logic check;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic finish_early;
    logic probe_next;
  } sts_t;

endpackage

/* src/csht_ram.sv */
// csht_ram: generic single-port RAM with registered read
// no dependencies

module csht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/csht_ctrl.sv */
// csht_ctrl: controller state machine (clearing pass, decode, probe loop)
// depends on csht_pkg

module csht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output csht_pkg::cmd_t cmd_o,
  input  csht_pkg::sts_t sts_i
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DECODE = 5'b00100,
    S_READ   = 5'b01000,
    S_CHECK  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = sts_i.finish_early ? S_IDLE : S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.probe_next ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* src/csht_dp.sv */
// csht_dp: datapath with request registers, config registers, slot RAM and result
// depends on csht_pkg and csht_ram

module csht_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  csht_pkg::cmd_t                    cmd_i,
  output csht_pkg::sts_t                    sts_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [csht_pkg::SizeW-1:0]        cfg_data_i,
  input  logic                              kind_i,
  input  logic [csht_pkg::SizeW-1:0]        alloc_size_i,
  input  logic [csht_pkg::HashW-1:0]        site_hash_i,
  input  logic [csht_pkg::FramesW-1:0]      frame_total_i,
  input  logic [csht_pkg::DigestW-1:0]      frame_digest_i,
  input  logic [csht_pkg::IdW-1:0]          release_site_i,
  output logic                              done_o,
  output logic [csht_pkg::IdW-1:0]          site_id_o,
  output logic signed [csht_pkg::BytesW-1:0] site_bytes_o,
  output logic signed [csht_pkg::AllocsW-1:0] site_allocs_o,
  output logic [1:0]                        status_o
);

  logic                               kind_q;
  logic [csht_pkg::SizeW-1:0]         size_q;
  logic [csht_pkg::HashW-1:0]         hash_q;
  logic [csht_pkg::FramesW-1:0]       frames_q;
  logic [csht_pkg::DigestW-1:0]       digest_q;
  logic                               bad_id_q;
  logic [csht_pkg::SlotAw-1:0]        idx_q, idx_d;
  logic [csht_pkg::SlotAw-1:0]        clr_q;
  logic [csht_pkg::IdW-1:0]           occ_q;
  logic                               en_q;
  logic [csht_pkg::SizeW-1:0]         thr_q;

  logic                               res_valid_q;
  logic [csht_pkg::IdW-1:0]           res_id_q;
  logic [csht_pkg::BytesW-1:0]        res_bytes_q;
  logic [csht_pkg::AllocsW-1:0]       res_allocs_q;
  logic [1:0]                         res_status_q;

  logic [csht_pkg::IdW-1:0]           rel_idx;
  csht_pkg::entry_t                   rd_entry, wr_entry;
  logic [csht_pkg::EntryW-1:0]        rd_data;
  logic [csht_pkg::SlotAw-1:0]        ram_addr;
  logic                               ram_we;
  logic                               untracked;
  logic                               key_match;
  logic                               is_full;
  logic                               do_update;
  logic [csht_pkg::BytesW-1:0]        size_ext;
  logic [csht_pkg::BytesW-1:0]        new_bytes;
  logic [csht_pkg::AllocsW-1:0]       new_allocs;

  assign rel_idx  = release_site_i - csht_pkg::IdW'(1);
  assign rd_entry = csht_pkg::entry_t'(rd_data);
  assign size_ext = csht_pkg::BytesW'(size_q);

  assign untracked = !en_q || (size_q < thr_q);
  assign key_match = (rd_entry.hash == hash_q) && (rd_entry.frames == frames_q) &&
                     (rd_entry.digest == digest_q);
  assign is_full   = (occ_q >= csht_pkg::OccLimit);

  always_comb begin
    if (kind_q == csht_pkg::KindRelease) begin
      do_update  = 1'b1;
      new_bytes  = rd_entry.bytes - size_ext;
      new_allocs = rd_entry.allocs - csht_pkg::AllocsW'(1);
      wr_entry   = rd_entry;
    end else begin
      do_update  = (rd_entry.live && key_match) || (!rd_entry.live && !is_full);
      new_bytes  = rd_entry.bytes + size_ext;
      new_allocs = rd_entry.allocs + csht_pkg::AllocsW'(1);
      wr_entry   = rd_entry;
      wr_entry.live   = 1'b1;
      wr_entry.hash   = hash_q;
      wr_entry.frames = frames_q;
      wr_entry.digest = digest_q;
    end
    wr_entry.bytes  = new_bytes;
    wr_entry.allocs = new_allocs;
    if (cmd_i.clear) begin
      wr_entry = '0;
    end
  end

  assign ram_addr = cmd_i.clear ? clr_q : idx_q;
  assign ram_we   = cmd_i.clear || (cmd_i.check && do_update);

  csht_ram #(
    .Width (csht_pkg::EntryW),
    .Depth (csht_pkg::Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.read),
    .rdata_o (rd_data)
  );

  assign sts_o.clear_done   = cmd_i.clear && (clr_q == {csht_pkg::SlotAw{1'b1}});
  assign sts_o.finish_early = (kind_q == csht_pkg::KindRelease) ? bad_id_q : untracked;
  assign sts_o.probe_next   = (kind_q == csht_pkg::KindRecord) && rd_entry.live && !key_match;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (kind_i == csht_pkg::KindRelease) ? rel_idx[csht_pkg::SlotAw-1:0]
                                                : site_hash_i[csht_pkg::SlotAw-1:0];
    end else if (cmd_i.check && sts_o.probe_next) begin
      idx_d = idx_q + csht_pkg::SlotAw'(1);
    end
  end

  // request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      size_q   <= alloc_size_i;
      hash_q   <= site_hash_i;
      frames_q <= (frame_total_i > csht_pkg::FramesSat) ? csht_pkg::FramesSat
                                                         : frame_total_i;
      digest_q <= frame_digest_i;
      bad_id_q <= (release_site_i == '0) ||
                  (release_site_i > csht_pkg::IdW'(csht_pkg::Slots));
    end
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      occ_q <= '0;
      en_q  <= 1'b0;
      thr_q <= csht_pkg::ThrReset;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + csht_pkg::SlotAw'(1);
      end
      if (cmd_i.check && (kind_q == csht_pkg::KindRecord) && !rd_entry.live && do_update) begin
        occ_q <= occ_q + csht_pkg::IdW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          csht_pkg::CfgEnable:    en_q  <= cfg_data_i[0];
          csht_pkg::CfgThreshold: thr_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= (cmd_i.decode && sts_o.finish_early) ||
                     (cmd_i.check && !sts_o.probe_next);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      res_id_q     <= '0;
      res_bytes_q  <= '0;
      res_allocs_q <= '0;
      res_status_q <= (kind_q == csht_pkg::KindRelease) ? csht_pkg::StatusBadId
                                                        : csht_pkg::StatusUntracked;
    end else if (cmd_i.check) begin
      if (do_update) begin
        res_id_q     <= (kind_q == csht_pkg::KindRelease) ? '0
                        : csht_pkg::IdW'(idx_q) + csht_pkg::IdW'(1);
        res_bytes_q  <= new_bytes;
        res_allocs_q <= new_allocs;
        res_status_q <= csht_pkg::StatusDone;
      end else begin
        res_id_q     <= '0;
        res_bytes_q  <= '0;
        res_allocs_q <= '0;
        res_status_q <= csht_pkg::StatusFull;
      end
    end
  end

  assign done_o        = res_valid_q;
  assign site_id_o     = res_id_q;
  assign site_bytes_o  = res_bytes_q;
  assign site_allocs_o = res_allocs_q;
  assign status_o      = res_status_q;

endmodule

/* src/call_site_hash_counter_table.sv */
// call_site_hash_counter_table: top level joining controller and datapath
// depends on csht_pkg, csht_ctrl, csht_dp (and csht_ram below it)

// After reset the block runs a clearing pass over all 8192 slots, one slot a
// cycle, and holds busy_o high until that pass is done. A request is taken when
// start_i is high and busy_o low. Every request gives exactly one result, shown
// for one cycle with done_o; it cannot be held off. An untracked record or a
// bad release id gives its result straight from the decode state; a release
// then takes one read and one check state; a record takes a read and a check
// state for each linear probe, one read of the single-port slot RAM followed
// by a compare. Config writes are always taken (cfg_ready_o is tied high).

module call_site_hash_counter_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                kind_i,
  input  logic [csht_pkg::SizeW-1:0]          alloc_size_i,
  input  logic [csht_pkg::HashW-1:0]          site_hash_i,
  input  logic [csht_pkg::FramesW-1:0]        frame_total_i,
  input  logic [csht_pkg::DigestW-1:0]        frame_digest_i,
  input  logic [csht_pkg::IdW-1:0]            release_site_i,
  output logic                                done_o,
  output logic [csht_pkg::IdW-1:0]            site_id_o,
  output logic signed [csht_pkg::BytesW-1:0]  site_bytes_o,
  output logic signed [csht_pkg::AllocsW-1:0] site_allocs_o,
  output logic [1:0]                          status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [csht_pkg::SizeW-1:0]          cfg_data_i
);

  csht_pkg::cmd_t cmd;
  csht_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  csht_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  csht_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .alloc_size_i   (alloc_size_i),
    .site_hash_i    (site_hash_i),
    .frame_total_i  (frame_total_i),
    .frame_digest_i (frame_digest_i),
    .release_site_i (release_site_i),
    .done_o         (done_o),
    .site_id_o      (site_id_o),
    .site_bytes_o   (site_bytes_o),
    .site_allocs_o  (site_allocs_o),
    .status_o       (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but block not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on back-to-back cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && site_id_o != '0) |-> (status_o == csht_pkg::StatusDone))
    else $error("site id given with a failing status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !cmd.clear)
    else $error("result during clearing pass");

endmodule
